// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== hdl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants for the matrix to quaternion core
// ----------------------------------------------------------------------------
package rmq_pkg;
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    MODE_TRACE = 2'd0,
    MODE_PIVOT = 2'd1,
    MODE_BAD   = 2'd2
  } mode_t;

  function automatic logic [1:0] next_axis(input logic [1:0] a);
    logic [1:0] r;
    case (a)
      AXIS_X:  r = AXIS_Y;
      AXIS_Y:  r = AXIS_Z;
      default: r = AXIS_X;
    endcase
    return r;
  endfunction
endpackage

// ===== hdl/rotation_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// 3x3 rotation matrix to unit quaternion, fixed point
// ----------------------------------------------------------------------------
// Takes one request per cycle (busy stays low) and returns each quaternion
// on done, high for one cycle; the receiver cannot stall. Each result passes
// the front register, the bit-per-stage root pipeline, then the bit-per-stage
// divider for the three scaled terms, and the output register.
module rotation_matrix_to_quaternion_core #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] qx, qy, qz, qw,
  output logic                         bad_matrix
);
  logic signed [DATA_WIDTH-1:0] e [9];
  logic fv, bv;
  rmq_pkg::mode_t fmode;
  logic [1:0] fpiv;
  logic [DATA_WIDTH+2:0] frad;
  logic signed [DATA_WIDTH+1:0] fnum [3];
  logic signed [DATA_WIDTH-1:0] q [4];

  assign busy = 1'b0;
  assign e = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

  rmq_front #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_front (
    .clk, .rst, .in_valid(start), .e,
    .out_valid(fv), .mode(fmode), .piv(fpiv), .rad(frad), .num(fnum)
  );

  rmq_back #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk, .rst, .in_valid(fv), .mode(fmode), .piv(fpiv), .rad(frad), .num(fnum),
    .out_valid(bv), .q, .bad(bad_matrix)
  );

  assign done = bv;
  assign qx = q[0];
  assign qy = q[1];
  assign qz = q[2];
  assign qw = q[3];
endmodule

// ===== hdl/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// classifies a matrix: trace, pivot or bad case, radicand and numerators
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int DW = 16,
  parameter int FB = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [DW-1:0] e [9],
  output logic                 out_valid,
  output rmq_pkg::mode_t       mode,
  output logic [1:0]           piv,
  output logic [DW+2:0]        rad,
  output logic signed [DW+1:0] num [3]
);
  localparam int RW = DW + 3;
  logic signed [RW-1:0] d [3];
  logic signed [RW-1:0] tr, one, rp;
  logic [1:0] i, j, k;
  logic signed [DW-1:0] mii, mjj, mkk;

  function automatic logic signed [DW-1:0] el(input logic signed [DW-1:0] a [9],
                                             input logic [1:0] r, input logic [1:0] c);
    logic [3:0] idx;
    idx = {2'b00, r} * 4'd3 + {2'b00, c};
    return a[idx];
  endfunction

  always_comb begin
    for (int n = 0; n < 3; n++) d[n] = RW'(e[n * 4]);
    one = RW'(1) <<< FB;
    tr = d[0] + d[1] + d[2];
    i = rmq_pkg::AXIS_X;
    if (e[4] > e[0]) i = rmq_pkg::AXIS_Y;
    if (e[8] > el(e, i, i)) i = rmq_pkg::AXIS_Z;
    j = rmq_pkg::next_axis(i);
    k = rmq_pkg::next_axis(j);
    mii = el(e, i, i);
    mjj = el(e, j, j);
    mkk = el(e, k, k);
    rp = RW'(mii) - RW'(mjj) - RW'(mkk) + one;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    piv <= i;
    if (tr > 0) begin
      mode   <= rmq_pkg::MODE_TRACE;
      rad    <= (DW+3)'(tr + one);
      num[0] <= (DW+2)'(e[7]) - (DW+2)'(e[5]);
      num[1] <= (DW+2)'(e[2]) - (DW+2)'(e[6]);
      num[2] <= (DW+2)'(e[3]) - (DW+2)'(e[1]);
    end else begin
      mode   <= (rp <= 0) ? rmq_pkg::MODE_BAD : rmq_pkg::MODE_PIVOT;
      rad    <= (DW+3)'(rp);
      num[0] <= (DW+2)'(el(e, k, j)) - (DW+2)'(el(e, j, k));
      num[1] <= (DW+2)'(el(e, j, i)) + (DW+2)'(el(e, i, j));
      num[2] <= (DW+2)'(el(e, k, i)) + (DW+2)'(el(e, i, k));
    end
  end
endmodule

// ===== hdl/rmq_back.sv =====
// ----------------------------------------------------------------------------
// rmq_back
// pipelined square root, restoring division and saturation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rmq_back #(
  parameter int DW = 16,
  parameter int FB = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  rmq_pkg::mode_t       mode,
  input  logic [1:0]           piv,
  input  logic [DW+2:0]        rad,
  input  logic signed [DW+1:0] num [3],
  output logic                 out_valid,
  output logic signed [DW-1:0] q [4],
  output logic                 bad
);
  // radicand shifted by FB, root width
  localparam int NW = DW + 3 + FB + ((DW + 3 + FB) % 2);
  localparam int SW = NW / 2;
  localparam int MW = DW + 1 + FB;    // |d| << FB
  localparam int QW = MW + 1;
  localparam int NS = SW;             // sqrt stages
  localparam int DS = QW;             // divide stages
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  // sqrt pipeline: one result bit per stage
  logic [NW-1:0]   sr_n [NS+1];
  logic [SW-1:0]   sr_r [NS+1];
  logic [NW+1:0]   sr_rem [NS+1];
  logic            sv [NS+1];
  rmq_pkg::mode_t  smode [NS+1];
  logic [1:0]      spiv [NS+1];
  logic            sneg [NS+1][3];
  logic [MW-1:0]   smag [NS+1][3];

  always_comb begin
    sv[0] = in_valid;
    sr_n[0] = NW'(rad) << FB;
    sr_r[0] = '0;
    sr_rem[0] = '0;
    smode[0] = mode;
    spiv[0] = piv;
    for (int n = 0; n < 3; n++) begin
      sneg[0][n] = num[n][DW+1];
      smag[0][n] = MW'(num[n][DW+1] ? -num[n] : num[n]) << FB;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    logic [NW+1:0] rem2, trial;
    always_comb begin
      rem2 = {sr_rem[g][NW-1:0], sr_n[g][NW-1 -: 2]};
      trial = {(NW+2-SW-2)'(0), sr_r[g], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) sv[g+1] <= 1'b0;
      else sv[g+1] <= sv[g];
      sr_n[g+1] <= sr_n[g] << 2;
      if (rem2 >= trial) begin
        sr_rem[g+1] <= rem2 - trial;
        sr_r[g+1] <= {sr_r[g][SW-2:0], 1'b1};
      end else begin
        sr_rem[g+1] <= rem2;
        sr_r[g+1] <= {sr_r[g][SW-2:0], 1'b0};
      end
      smode[g+1] <= smode[g];
      spiv[g+1] <= spiv[g];
      sneg[g+1] <= sneg[g];
      smag[g+1] <= smag[g];
    end
  end

  // restoring division: (mag + s) / (2 s), one quotient bit per stage
  localparam int RWD = QW + SW + 2;
  logic            dv [DS+1];
  rmq_pkg::mode_t  dmode [DS+1];
  logic [1:0]      dpiv [DS+1];
  logic [SW-1:0]   ds [DS+1];
  logic            dneg [DS+1][3];
  logic [QW-1:0]   dnum [DS+1][3];
  logic [QW-1:0]   dq [DS+1][3];
  logic [RWD-1:0]  drem [DS+1][3];

  always_comb begin
    dv[0] = sv[NS];
    dmode[0] = smode[NS];
    dpiv[0] = spiv[NS];
    ds[0] = sr_r[NS];
    for (int n = 0; n < 3; n++) begin
      dneg[0][n] = sneg[NS][n];
      dnum[0][n] = QW'(smag[NS][n]) + QW'(sr_r[NS]);
      dq[0][n] = '0;
      drem[0][n] = '0;
    end
  end

  for (genvar g = 0; g < DS; g++) begin : g_div
    logic [RWD-1:0] r2 [3];
    logic [RWD-1:0] dvs;
    always_comb begin
      dvs = RWD'(ds[g]) << 1;
      for (int n = 0; n < 3; n++) r2[n] = {drem[g][n][RWD-2:0], dnum[g][n][QW-1-g]};
    end
    always_ff @(posedge clk) begin
      if (rst) dv[g+1] <= 1'b0;
      else dv[g+1] <= dv[g];
      dmode[g+1] <= dmode[g];
      dpiv[g+1] <= dpiv[g];
      ds[g+1] <= ds[g];
      dneg[g+1] <= dneg[g];
      dnum[g+1] <= dnum[g];
      for (int n = 0; n < 3; n++) begin
        if (r2[n] >= dvs) begin
          drem[g+1][n] <= r2[n] - dvs;
          dq[g+1][n] <= dq[g][n] | (QW'(1) << (QW-1-g));
        end else begin
          drem[g+1][n] <= r2[n];
          dq[g+1][n] <= dq[g][n];
        end
      end
    end
  end

  function automatic logic signed [DW-1:0] sat_term(input logic neg, input logic [QW-1:0] m);
    logic signed [DW-1:0] r;
    if (!neg) r = (m > QW'(SMAX)) ? SMAX : DW'(m);
    else r = (m > QW'(SMAX) + QW'(1)) ? SMIN : DW'(-m);
    return r;
  endfunction

  logic [SW:0] half;
  logic signed [DW-1:0] hs, t0, t1, t2;
  logic [1:0] jx, kx;
  logic signed [DW-1:0] q_next [4];
  always_comb begin
    half = ({1'b0, ds[DS]} + (SW+1)'(1)) >> 1;
    hs = sat_term(1'b0, QW'(half));
    t0 = sat_term(dneg[DS][0], dq[DS][0]);
    t1 = sat_term(dneg[DS][1], dq[DS][1]);
    t2 = sat_term(dneg[DS][2], dq[DS][2]);
    jx = rmq_pkg::next_axis(dpiv[DS]);
    kx = rmq_pkg::next_axis(jx);
    for (int n = 0; n < 4; n++) q_next[n] = '0;
    case (dmode[DS])
      rmq_pkg::MODE_TRACE: begin
        q_next[3] = hs; q_next[0] = t0; q_next[1] = t1; q_next[2] = t2;
      end
      rmq_pkg::MODE_PIVOT: begin
        q_next[dpiv[DS]] = hs; q_next[3] = t0; q_next[jx] = t1; q_next[kx] = t2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= dv[DS];
    bad <= (dmode[DS] == rmq_pkg::MODE_BAD);
    q <= q_next;
  end

  `ASSERT_CLK(a_valid_follows, clk, rst, dv[DS] |=> out_valid, "result lost")
  `ASSERT_CLK(a_no_spurious, clk, rst, !dv[DS] |=> !out_valid, "spurious result")
  `ASSERT_CLK(a_bad_zero, clk, rst, (out_valid && bad) |-> (q[0] == 0 && q[3] == 0),
    "bad matrix not zero")
endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// matrix to quaternion core: directed corner matrices, then random rotations
// and raw bit patterns, checked against a bit-exact quaternion predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  localparam int DW = 16;
  localparam int FB = 14;
  localparam int LATENCY = 2 + (DW + FB + 4) / 2 + (DW + FB + 2);
  localparam longint ONE = longint'(1) << FB;
  localparam longint QMAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint QMIN = -QMAX - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  typedef logic signed [DW-1:0] mat_t [3][3];
  typedef struct {
    logic signed [DW-1:0] x, y, z, w;
    logic bad;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, bad_matrix;
  logic signed [DW-1:0] qx, qy, qz, qw;
  mat_t mx;

  quat_t quat_queue [$];
  int errors = 0;
  int cycles = 0;

  always #2 clk = ~clk;

  rotation_matrix_to_quaternion_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .m00(mx[0][0]), .m01(mx[0][1]), .m02(mx[0][2]),
    .m10(mx[1][0]), .m11(mx[1][1]), .m12(mx[1][2]),
    .m20(mx[2][0]), .m21(mx[2][1]), .m22(mx[2][2]),
    .done(done), .qx(qx), .qy(qy), .qz(qz), .qw(qw), .bad_matrix(bad_matrix)
  );

  initial begin
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        mx[r][c] = '0;
  end

  function automatic longint clamp_q(input longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint int_root(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  // numerator over twice the root, rounded half away from zero
  function automatic longint ratio_term(input longint d, input longint s);
    longint mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag << FB) + s) / (2 * s);
    return clamp_q(d < 0 ? -q : q);
  endfunction

  function automatic quat_t quat_of_matrix(input mat_t mat);
    longint m [3][3];
    longint q [4];
    longint tr, rad, s;
    int i, j, k;
    quat_t res;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = longint'(mat[r][c]);
    for (int n = 0; n < 4; n++) q[n] = 0;
    res.bad = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      rad = tr + ONE;
      s = int_root(rad << FB);
      q[3] = clamp_q((s + 1) >> 1);
      q[0] = ratio_term(m[2][1] - m[1][2], s);
      q[1] = ratio_term(m[0][2] - m[2][0], s);
      q[2] = ratio_term(m[1][0] - m[0][1], s);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      rad = m[i][i] - m[j][j] - m[k][k] + ONE;
      if (rad <= 0) begin
        res.bad = 1'b1;
      end else begin
        s = int_root(rad << FB);
        q[i] = clamp_q((s + 1) >> 1);
        q[3] = ratio_term(m[k][j] - m[j][k], s);
        q[j] = ratio_term(m[j][i] + m[i][j], s);
        q[k] = ratio_term(m[k][i] + m[i][k], s);
      end
    end
    res.x = q[0][DW-1:0];
    res.y = q[1][DW-1:0];
    res.z = q[2][DW-1:0];
    res.w = q[3][DW-1:0];
    return res;
  endfunction

  // called at a rising edge; returns at the rising edge that takes the request
  task automatic send_request(input mat_t mat, input int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        mx[r][c] <= mat[r][c];
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    quat_queue.push_back(quat_of_matrix(mat));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    quat_t e;
    if (!rst && done) begin
      if (quat_queue.size() == 0) begin
        $display("%0t: result with no request pending: %h %h %h %h %b", $time,
                 qx, qy, qz, qw, bad_matrix);
        errors++;
      end else begin
        e = quat_queue.pop_front();
        if (qx !== e.x) begin
          $display("%0t: qx expected %h actual %h", $time, e.x, qx); errors++;
        end
        if (qy !== e.y) begin
          $display("%0t: qy expected %h actual %h", $time, e.y, qy); errors++;
        end
        if (qz !== e.z) begin
          $display("%0t: qz expected %h actual %h", $time, e.z, qz); errors++;
        end
        if (qw !== e.w) begin
          $display("%0t: qw expected %h actual %h", $time, e.w, qw); errors++;
        end
        if (bad_matrix !== e.bad) begin
          $display("%0t: bad_matrix expected %b actual %b", $time, e.bad, bad_matrix);
          errors++;
        end
      end
    end
  end

  function automatic mat_t diag_matrix(input int a, input int b, input int c, input int off);
    mat_t m;
    for (int r = 0; r < 3; r++)
      for (int cc = 0; cc < 3; cc++)
        m[r][cc] = DW'(off);
    m[0][0] = DW'(a); m[1][1] = DW'(b); m[2][2] = DW'(c);
    return m;
  endfunction

  function automatic logic signed [DW-1:0] to_fix(input real v);
    int n;
    n = $rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5));
    n = n + $urandom_range(6) - 3;
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return DW'(n);
  endfunction

  function automatic real rand_unit();
    return (real'(int'($urandom_range(20000))) - 10000.0) / 10000.0;
  endfunction

  function automatic mat_t random_rotation();
    real x, y, z, w, n;
    mat_t m;
    do begin
      x = rand_unit(); y = rand_unit(); z = rand_unit(); w = rand_unit();
      n = x * x + y * y + z * z + w * w;
    end while (n < 0.01);
    n = $sqrt(n);
    x = x / n; y = y / n; z = z / n; w = w / n;
    m[0][0] = to_fix(1.0 - 2.0 * (y * y + z * z));
    m[0][1] = to_fix(2.0 * (x * y - z * w));
    m[0][2] = to_fix(2.0 * (x * z + y * w));
    m[1][0] = to_fix(2.0 * (x * y + z * w));
    m[1][1] = to_fix(1.0 - 2.0 * (x * x + z * z));
    m[1][2] = to_fix(2.0 * (y * z - x * w));
    m[2][0] = to_fix(2.0 * (x * z - y * w));
    m[2][1] = to_fix(2.0 * (y * z + x * w));
    m[2][2] = to_fix(1.0 - 2.0 * (x * x + y * y));
    return m;
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    int kind;
    kind = $urandom_range(99);
    if (kind < 60) return random_rotation();
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        if (kind < 80) m[r][c] = DW'($urandom);
        else m[r][c] = DW'(int'($urandom_range(40000)) - 20000);
    return m;
  endfunction

  task automatic test_corners();
    mat_t m;
    send_request(diag_matrix(0, 0, 0, 0), 0);
    send_request(diag_matrix(16384, 16384, 16384, 0), 0);
    send_request(diag_matrix(-16384, -16384, -16384, 0), 0);
    send_request(diag_matrix(32767, 32767, 32767, 32767), 0);
    send_request(diag_matrix(-32768, -32768, -32768, -32768), 0);
    send_request(diag_matrix(32767, 32767, 32767, -32768), 0);
    send_request(diag_matrix(-32768, -32768, -32768, 32767), 0);
    // trace just positive, differences saturate
    m = diag_matrix(1, 0, 0, 0);
    m[2][1] = VMAX; m[1][2] = VMIN; m[0][2] = VMIN; m[2][0] = VMAX;
    m[1][0] = VMAX; m[0][1] = VMIN;
    send_request(m, 0);
    // trace exactly zero
    send_request(diag_matrix(16384, -8192, -8192, 100), 0);
    // each pivot axis
    send_request(diag_matrix(16384, -16384, -16384, 0), 0);
    send_request(diag_matrix(-16384, 16384, -16384, 0), 0);
    send_request(diag_matrix(-16384, -16384, 16384, 0), 0);
    // pivot ties keep the lower index
    send_request(diag_matrix(-5000, -5000, -5000, 1234), 0);
    send_request(diag_matrix(-9000, 2000, 2000, -777), 0);
    send_request(diag_matrix(3000, 3000, -20000, 4321), 0);
    send_request(diag_matrix(-32768, 32767, -32768, -32768), 0);
    send_request(diag_matrix(32767, -32768, -32768, 32767), 0);
    m = diag_matrix(-32768, -32768, 32767, 0);
    m[0][2] = VMAX; m[2][0] = VMAX; m[1][2] = VMIN; m[2][1] = VMIN;
    send_request(m, 0);
    wait_drained();
  endtask

  task automatic test_random(input int count, input int idle_pct);
    for (int n = 0; n < count; n++) send_request(random_matrix(), idle_pct);
  endtask

  task automatic test_drain_pause();
    test_random(20, 10);
    wait_drained();
    test_random(20, 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_random(400, 36);
    test_drain_pause();
    test_random(380, 74);
    test_random(330, 0);
    wait_drained();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/rmq_pkg.sv
hdl/rmq_front.sv
hdl/rmq_back.sv
hdl/rotation_matrix_to_quaternion_core.sv
test/testbench.sv
